>>> rtl/rfi_pkg.sv
`timescale 1ns / 1ps
// rfi_pkg: shared constants, codes and types for the forest inference block
// no dependencies

package rfi_pkg;
	localparam int MAX_TREES      = 256;
	localparam int NODES_PER_TREE = 16;
	localparam int NUM_FEATURES   = 256;
	localparam int VALUE_BITS     = 16;

	localparam int TREE_BITS = $clog2(MAX_TREES);
	localparam int NODE_BITS = $clog2(NODES_PER_TREE);
	localparam int FEAT_BITS = $clog2(NUM_FEATURES);
	localparam int ADDR_BITS = TREE_BITS + NODE_BITS;
	localparam int CNT_BITS  = 9;
	localparam int SUM_BITS  = VALUE_BITS + CNT_BITS;

	localparam logic [1:0] OP_NODE = 2'd0;
	localparam logic [1:0] OP_FEAT = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	typedef struct packed {
		logic [3:0]                   left;
		logic [3:0]                   right;
		logic [7:0]                   feat;
		logic signed [VALUE_BITS-1:0] split;
	} node_t;
endpackage

>>> rtl/random_forest_inference.sv
`timescale 1ns / 1ps
// random_forest_inference: node and feature memories, tree walker, mean divider
// depends on rfi_pkg
//
//  channel   direction  handshake        payload
//  in        input      in_valid/ready   op .. feature_value
//  out       output     out_valid/ready  prediction, depth_error
//  cfg       input      cfg_we           cfg_wdata (tree_count)
//
// an evaluation walks each inner node visited through node read, node decode with
// feature read and compare, and each leaf through node read and node decode,
// then a next-tree step per tree and a restoring divider over SUM_BITS bits.
// reset clears control state only; memories are undefined until written.
// input stalls while an evaluation runs or its result waits on out_ready.

module random_forest_inference (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  tree_index,
	input  logic [3:0]  node_index,
	input  logic [3:0]  left_child,
	input  logic [3:0]  right_child,
	input  logic [7:0]  split_feature,
	input  logic signed [15:0] split_value,
	input  logic [7:0]  feature_index,
	input  logic signed [15:0] feature_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] prediction,
	output logic        depth_error
);
	localparam int VB = rfi_pkg::VALUE_BITS;
	localparam int SB = rfi_pkg::SUM_BITS;
	localparam int CB = rfi_pkg::CNT_BITS;
	localparam int NB = rfi_pkg::NODE_BITS;
	localparam int TB = rfi_pkg::TREE_BITS;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_NRD   = 7'b0000010,
		ST_NODE  = 7'b0000100,
		ST_FEAT  = 7'b0001000,
		ST_NEXT  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CB-1:0] tree_count_q, count_q, tree_q;
	logic [NB-1:0] cur_q;
	logic [NB:0]   visits_q;
	logic signed [SB-1:0] sum_q;
	logic err_q;
	rfi_pkg::node_t node_mem [rfi_pkg::MAX_TREES*rfi_pkg::NODES_PER_TREE];
	logic signed [VB-1:0] feat_mem [rfi_pkg::NUM_FEATURES];
	rfi_pkg::node_t node_rd, node_hold_q;
	logic signed [VB-1:0] feat_rd;
	logic [SB-1:0] mag_q, quo_q, rem_q;
	logic [$clog2(SB+1)-1:0] div_cnt_q;
	logic neg_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	wire accept = in_valid && in_ready;

	wire [rfi_pkg::ADDR_BITS-1:0] node_addr = {tree_q[TB-1:0], cur_q};

	always_ff @(posedge clk) begin
		if (accept && op == rfi_pkg::OP_NODE)
			node_mem[{tree_index, node_index}] <= '{left_child, right_child,
				split_feature, split_value};
		node_rd <= node_mem[node_addr];
	end

	// feature address comes straight from the node just read
	always_ff @(posedge clk) begin
		if (accept && op == rfi_pkg::OP_FEAT)
			feat_mem[feature_index] <= feature_value;
		feat_rd <= feat_mem[node_rd.feat];
	end

	logic [SB:0] rem_try;
	assign rem_try = {rem_q, mag_q[SB-1]} - {{(SB+1-CB){1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tree_count_q <= 9'd1;
		end else begin
			if (cfg_we)
				tree_count_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: if (accept && op == rfi_pkg::OP_EVAL) state_q <= ST_NRD;
				ST_NRD:  state_q <= ST_NODE;
				ST_NODE: begin
					if (node_rd.left == '0 && node_rd.right == '0)
						state_q <= ST_NEXT;
					else
						state_q <= ST_FEAT;
				end
				ST_FEAT: begin
					if (visits_q == (NB+1)'(rfi_pkg::NODES_PER_TREE))
						state_q <= ST_NEXT;
					else
						state_q <= ST_NRD;
				end
				ST_NEXT: state_q <= (tree_q + 1'b1 == count_q) ? ST_DIV : ST_NRD;
				ST_DIV:  if (div_cnt_q == '0) state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				count_q <= (tree_count_q == '0) ? CB'(1) :
					(tree_count_q > CB'(rfi_pkg::MAX_TREES)) ?
					CB'(rfi_pkg::MAX_TREES) : tree_count_q;
				tree_q   <= '0;
				cur_q    <= '0;
				visits_q <= '0;
				sum_q    <= '0;
				err_q    <= 1'b0;
			end
			ST_NODE: begin
				node_hold_q <= node_rd;
				visits_q    <= visits_q + 1'b1;
				if (node_rd.left == '0 && node_rd.right == '0)
					sum_q <= sum_q + SB'(node_rd.split);
			end
			ST_FEAT: begin
				// out-of-range feature reads as zero
				if (((rfi_pkg::NUM_FEATURES >= 256) ? 1'b1 :
						(node_hold_q.feat < 8'(rfi_pkg::NUM_FEATURES))) ?
						(feat_rd <= node_hold_q.split) : (node_hold_q.split >= 0))
					cur_q <= node_hold_q.left[NB-1:0];
				else
					cur_q <= node_hold_q.right[NB-1:0];
				if (visits_q == (NB+1)'(rfi_pkg::NODES_PER_TREE))
					err_q <= 1'b1;
			end
			ST_NEXT: begin
				tree_q   <= tree_q + 1'b1;
				cur_q    <= '0;
				visits_q <= '0;
				neg_q    <= sum_q[SB-1];
				mag_q    <= sum_q[SB-1] ? SB'(-sum_q) : SB'(sum_q);
				rem_q    <= '0;
				quo_q    <= '0;
				div_cnt_q <= ($clog2(SB+1))'(SB);
			end
			ST_DIV: begin
				if (div_cnt_q != '0) begin
					mag_q <= mag_q << 1;
					if (!rem_try[SB]) begin
						rem_q <= rem_try[SB-1:0];
						quo_q <= {quo_q[SB-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SB-2:0], mag_q[SB-1]};
						quo_q <= {quo_q[SB-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	logic [SB-1:0] quo_s;
	assign quo_s = neg_q ? SB'(-quo_q) : quo_q;
	assign prediction = quo_s[VB-1:0];
	assign depth_error = err_q;
endmodule
